>>> rtl/i2cm_pkg.sv
// Shared types, codes and constants of the two-wire bus master sequencer.
package i2cm_pkg;

	localparam int unsigned I2CM_BUFFER_DEPTH = 16;

	localparam logic [2:0] MODE_LOAD  = 3'd0;
	localparam logic [2:0] MODE_START = 3'd1;
	localparam logic [2:0] MODE_EVENT = 3'd2;
	localparam logic [2:0] MODE_READ  = 3'd3;
	localparam logic [2:0] MODE_RETRY = 3'd4;

	localparam logic [7:0] STATUS_MASK      = 8'hFC;
	localparam logic [7:0] ST_START         = 8'h08;
	localparam logic [7:0] ST_REP_START     = 8'h10;
	localparam logic [7:0] ST_MTX_ADR_ACK   = 8'h18;
	localparam logic [7:0] ST_MTX_ADR_NACK  = 8'h20;
	localparam logic [7:0] ST_MTX_DATA_ACK  = 8'h28;
	localparam logic [7:0] ST_ARB_LOST      = 8'h38;
	localparam logic [7:0] ST_MRX_ADR_ACK   = 8'h40;
	localparam logic [7:0] ST_MRX_ADR_NACK  = 8'h48;
	localparam logic [7:0] ST_MRX_DATA_ACK  = 8'h50;
	localparam logic [7:0] ST_MRX_DATA_NACK = 8'h58;

	localparam logic [2:0] ACT_NONE    = 3'd0;
	localparam logic [2:0] ACT_START   = 3'd1;
	localparam logic [2:0] ACT_TX      = 3'd2;
	localparam logic [2:0] ACT_RX_ACK  = 3'd3;
	localparam logic [2:0] ACT_RX_NACK = 3'd4;
	localparam logic [2:0] ACT_STOP    = 3'd5;
	localparam logic [2:0] ACT_DISABLE = 3'd6;

	typedef enum logic [1:0] {
		WSEL_SLOT,
		WSEL_ADDR,
		WSEL_PTR
	} wsel_t;

	typedef enum logic [1:0] {
		PTR_HOLD,
		PTR_ZERO,
		PTR_ONE,
		PTR_INC
	} ptr_op_t;

	typedef struct packed {
		logic       capture;
		logic       out_load;
		logic       mem_we;
		wsel_t      wsel;
		ptr_op_t    ptr_op;
		logic       len_load;
		logic       clear_status;
		logic       set_busy;
		logic       clr_busy;
		logic       set_success;
		logic       latch_err;
		logic       tx_en;
		logic       rd_en;
		logic [2:0] action;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] code;
		logic       busy;
		logic       success;
		logic       err;
		logic       retry_ok;
		logic       slot_ok;
		logic       ptr_ok;
		logic       zero_ok;
		logic       rx_more;
		logic       rx_more_inc;
	} dp_status_t;

endpackage

>>> rtl/i2cm_datapath.sv
// Datapath of the sequencer: item registers, frame buffer, pointer, flags and result register.
module i2cm_datapath import i2cm_pkg::*; #(
	parameter int unsigned BUFFER_DEPTH = I2CM_BUFFER_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [39:0]      in_data,
	input  dp_cmd_t          cmd,
	output dp_status_t       status,
	output logic [31:0]      out_data
);

	localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int unsigned PW = $clog2(BUFFER_DEPTH + 1);
	localparam int unsigned CW = PW + 5;

	logic [7:0]    mem_q [BUFFER_DEPTH];
	logic [2:0]    mode_q;
	logic [6:0]    addr_q;
	logic          rnw_q;
	logic [3:0]    count_q;
	logic [4:0]    slot_q;
	logic [7:0]    data_q;
	logic [7:0]    bstat_q;
	logic [7:0]    rd_data_q;
	logic [PW-1:0] ptr_q;
	logic [PW-1:0] len_q;
	logic          busy_q;
	logic          success_q;
	logic          err_q;
	logic [7:0]    err_code_q;
	logic [31:0]   out_q;

	logic [2:0]    in_mode;
	logic [7:0]    in_code;
	logic [4:0]    in_slot;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic [7:0]    code;
	logic [CW-1:0] slot_ext;
	logic [CW-1:0] cnt_ext;
	logic [CW-1:0] ptr_ext;
	logic [CW-1:0] len_ext;
	logic [PW-1:0] len_next;
	logic [7:0]    err_masked;

	assign in_mode = in_data[2:0];
	assign in_code = in_data[34:27] & STATUS_MASK;
	assign in_slot = {1'b0, in_data[18:15]} + 5'd1;

	always_comb begin
		if (in_mode == MODE_READ) begin
			rd_addr = AW'(in_slot);
		end else if (in_code == ST_START || in_code == ST_REP_START) begin
			rd_addr = '0;
		end else begin
			rd_addr = AW'(ptr_q);
		end
	end

	assign code     = bstat_q & STATUS_MASK;
	assign slot_ext = CW'(slot_q);
	assign cnt_ext  = CW'(count_q) + CW'(1);
	assign ptr_ext  = CW'(ptr_q);
	assign len_ext  = CW'(len_q);
	assign len_next = (cnt_ext > CW'(BUFFER_DEPTH)) ? PW'(BUFFER_DEPTH) : cnt_ext[PW-1:0];
	assign err_masked = err_code_q & STATUS_MASK;

	always_comb begin
		status.mode        = mode_q;
		status.code        = code;
		status.busy        = busy_q;
		status.success     = success_q;
		status.err         = err_q;
		status.retry_ok    = err_q && (err_masked == ST_MTX_ADR_NACK ||
			err_masked == ST_MRX_ADR_NACK);
		status.slot_ok     = slot_ext < CW'(BUFFER_DEPTH);
		status.ptr_ok      = (ptr_ext < len_ext) && (ptr_ext < CW'(BUFFER_DEPTH));
		status.zero_ok     = len_q != '0;
		status.rx_more     = (ptr_ext + CW'(1)) < len_ext;
		status.rx_more_inc = (ptr_ext + CW'(2)) < len_ext;
	end

	always_comb begin
		case (cmd.wsel)
			WSEL_SLOT: begin
				wr_addr = AW'(slot_q);
				wr_data = data_q;
			end
			WSEL_ADDR: begin
				wr_addr = '0;
				wr_data = {addr_q, rnw_q};
			end
			WSEL_PTR: begin
				wr_addr = AW'(ptr_q);
				wr_data = data_q;
			end
			default: begin
				wr_addr = '0;
				wr_data = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q    <= in_mode;
			addr_q    <= in_data[9:3];
			rnw_q     <= in_data[10];
			count_q   <= in_data[14:11];
			slot_q    <= in_slot;
			data_q    <= in_data[26:19];
			bstat_q   <= in_data[34:27];
			rd_data_q <= mem_q[rd_addr];
		end
		if (cmd.mem_we) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			len_q      <= '0;
			busy_q     <= 1'b0;
			success_q  <= 1'b0;
			err_q      <= 1'b0;
			err_code_q <= '0;
		end else begin
			case (cmd.ptr_op)
				PTR_HOLD: ptr_q <= ptr_q;
				PTR_ZERO: ptr_q <= '0;
				PTR_ONE:  ptr_q <= PW'(1);
				PTR_INC:  ptr_q <= ptr_q + PW'(1);
				default:  ptr_q <= ptr_q;
			endcase
			if (cmd.len_load) begin
				len_q <= len_next;
			end
			if (cmd.clear_status) begin
				success_q  <= 1'b0;
				err_q      <= 1'b0;
				err_code_q <= '0;
			end
			if (cmd.set_success) begin
				success_q <= 1'b1;
			end
			if (cmd.latch_err) begin
				err_q      <= 1'b1;
				err_code_q <= bstat_q;
			end
			if (cmd.set_busy) begin
				busy_q <= 1'b1;
			end else if (cmd.clr_busy) begin
				busy_q <= 1'b0;
			end
		end
	end

	// The result reports the flags as they stand after this item.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q[2:0]   <= cmd.action;
			out_q[10:3]  <= cmd.tx_en ? rd_data_q : 8'd0;
			out_q[11]    <= cmd.set_busy | (busy_q & ~cmd.clr_busy);
			out_q[12]    <= cmd.set_success | (success_q & ~cmd.clear_status);
			out_q[13]    <= cmd.latch_err | (err_q & ~cmd.clear_status);
			out_q[21:14] <= cmd.latch_err ? bstat_q :
				(cmd.clear_status ? 8'd0 : err_code_q);
			out_q[29:22] <= cmd.rd_en ? rd_data_q : 8'd0;
			out_q[30]    <= cmd.rd_en;
			out_q[31]    <= 1'b0;
		end
	end

	assign out_data = out_q;

endmodule

>>> rtl/i2cm_ctrl.sv
// Controller of the sequencer: handshake state machine and command decode.
module i2cm_ctrl import i2cm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   exec;

	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign exec      = state_q == S_EXEC;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd              = '0;
		cmd.wsel         = WSEL_SLOT;
		cmd.ptr_op       = PTR_HOLD;
		cmd.action       = ACT_NONE;
		cmd.capture      = accept;
		cmd.out_load     = exec;
		if (exec) begin
			case (status.mode)
				MODE_LOAD: begin
					cmd.mem_we = !status.busy && status.slot_ok;
					cmd.wsel   = WSEL_SLOT;
				end
				MODE_START: begin
					if (!status.busy) begin
						cmd.mem_we       = 1'b1;
						cmd.wsel         = WSEL_ADDR;
						cmd.len_load     = 1'b1;
						cmd.clear_status = 1'b1;
						cmd.set_busy     = 1'b1;
						cmd.action       = ACT_START;
					end
				end
				MODE_EVENT: begin
					if (status.busy) begin
						case (status.code)
							ST_START, ST_REP_START: begin
								if (status.zero_ok) begin
									cmd.tx_en  = 1'b1;
									cmd.ptr_op = PTR_ONE;
									cmd.action = ACT_TX;
								end else begin
									cmd.ptr_op      = PTR_ZERO;
									cmd.set_success = 1'b1;
									cmd.clr_busy    = 1'b1;
									cmd.action      = ACT_STOP;
								end
							end
							ST_MTX_ADR_ACK, ST_MTX_DATA_ACK: begin
								if (status.ptr_ok) begin
									cmd.tx_en  = 1'b1;
									cmd.ptr_op = PTR_INC;
									cmd.action = ACT_TX;
								end else begin
									cmd.set_success = 1'b1;
									cmd.clr_busy    = 1'b1;
									cmd.action      = ACT_STOP;
								end
							end
							ST_MRX_DATA_ACK: begin
								if (status.ptr_ok) begin
									cmd.mem_we = 1'b1;
									cmd.wsel   = WSEL_PTR;
									cmd.ptr_op = PTR_INC;
									cmd.action = status.rx_more_inc ? ACT_RX_ACK : ACT_RX_NACK;
								end else begin
									cmd.action = status.rx_more ? ACT_RX_ACK : ACT_RX_NACK;
								end
							end
							ST_MRX_ADR_ACK: begin
								cmd.action = status.rx_more ? ACT_RX_ACK : ACT_RX_NACK;
							end
							ST_MRX_DATA_NACK: begin
								cmd.mem_we      = status.ptr_ok;
								cmd.wsel        = WSEL_PTR;
								cmd.set_success = 1'b1;
								cmd.clr_busy    = 1'b1;
								cmd.action      = ACT_STOP;
							end
							ST_ARB_LOST: begin
								cmd.action = ACT_START;
							end
							default: begin
								cmd.latch_err = 1'b1;
								cmd.clr_busy  = 1'b1;
								cmd.action    = ACT_DISABLE;
							end
						endcase
					end
				end
				MODE_READ: begin
					cmd.rd_en = !status.busy && status.success && status.slot_ok;
				end
				MODE_RETRY: begin
					if (!status.busy && status.retry_ok) begin
						cmd.clear_status = 1'b1;
						cmd.set_busy     = 1'b1;
						cmd.action       = ACT_START;
					end
				end
				default: begin
					cmd.action = ACT_NONE;
				end
			endcase
		end
	end

endmodule

>>> rtl/i2c_master_transfer_sequencer.sv
// Top level of the two-wire bus master transfer sequencer.
// Flow: an accepted item is captured, executed in the execute state, and its result registered.
// A new item is taken only after the last one has executed; the buffer read registered at the accept edge
// is used in the execute cycle, and a new item waits while a result item is not taken.
// Reset: arst_n clears pointer, frame length and all flags at once; the frame
// buffer holds no defined value until written.
module i2c_master_transfer_sequencer import i2cm_pkg::*; #(
	parameter int unsigned BUFFER_DEPTH = I2CM_BUFFER_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// mode[2:0], device_address[9:3], read_not_write[10], byte_count[14:11],
	// byte_index[18:15], data_byte[26:19], bus_status[34:27], zero[39:35]
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// bus_action[2:0], tx_byte[10:3], busy_res[11], transfer_ok[12],
	// error_valid[13], error_status[21:14], read_byte[29:22], read_valid[30], zero[31]
	output logic [31:0] m_tdata
);

	dp_cmd_t    cmd;
	dp_status_t status;

	i2cm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	i2cm_datapath #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (s_tdata),
		.cmd      (cmd),
		.status   (status),
		.out_data (m_tdata)
	);

	a_accept_empties_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !m_tvalid)
		else $error("result register not free after an accepted item");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##2 m_tvalid)
		else $error("no result two cycles after an accepted item");

	a_tx_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == ACT_TX || m_tdata[2:0] == ACT_START) |-> m_tdata[11])
		else $error("transmit or start reported while idle");

	a_read_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[30] |-> m_tdata[12] && !m_tdata[11])
		else $error("read reported without a successful idle frame");

endmodule

>>> tb/sv/i2c_master_transfer_sequencer_checker.sv
`timescale 1ns / 100ps
// Checker that predicts every result item of the transfer sequencer and compares it.
module i2c_master_transfer_sequencer_checker import i2cm_pkg::*; #(
	parameter int unsigned BUFFER_DEPTH = I2CM_BUFFER_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	// mode[2:0], device_address[9:3], read_not_write[10], byte_count[14:11],
	// byte_index[18:15], data_byte[26:19], bus_status[34:27], zero[39:35]
	input  logic [39:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	// bus_action[2:0], tx_byte[10:3], busy_res[11], transfer_ok[12],
	// error_valid[13], error_status[21:14], read_byte[29:22], read_valid[30], zero[31]
	input  logic [31:0] m_tdata,
	output int          mismatch_count,
	output int          outstanding
);

	localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

	typedef struct packed {
		logic       pad;
		logic       read_valid;
		logic [7:0] read_byte;
		logic [7:0] error_status;
		logic       error_valid;
		logic       transfer_ok;
		logic       busy_res;
		logic [7:0] tx_byte;
		logic [2:0] bus_action;
	} seq_result_t;

	seq_result_t expected_q[$];

	logic [7:0] frame_mem [BUFFER_DEPTH];
	int         ptr;
	int         flen;
	logic       busy;
	logic       success;
	logic       err;
	logic [7:0] ecode;
	int         failures = 0;

	task automatic predict_result(input logic [39:0] item, output seq_result_t res);
		logic [2:0] mode;
		logic [6:0] addr;
		logic       rnw;
		int         count;
		int         slot;
		logic [7:0] data;
		logic [7:0] status;
		logic [7:0] code;
		mode   = item[2:0];
		addr   = item[9:3];
		rnw    = item[10];
		count  = int'(item[14:11]);
		slot   = int'(item[18:15]) + 1;
		data   = item[26:19];
		status = item[34:27];
		code   = status & STATUS_MASK;
		res    = '0;
		case (mode)
			MODE_LOAD: begin
				if (!busy && slot < BUFFER_DEPTH)
					frame_mem[AW'(slot)] = data;
			end
			MODE_START: begin
				if (!busy) begin
					frame_mem[0] = {addr, rnw};
					flen = count + 1;
					if (flen > BUFFER_DEPTH)
						flen = BUFFER_DEPTH;
					success = 1'b0;
					err = 1'b0;
					ecode = 8'h00;
					busy = 1'b1;
					res.bus_action = ACT_START;
				end
			end
			MODE_EVENT: begin
				if (busy) begin
					if (code == ST_START || code == ST_REP_START)
						ptr = 0;
					case (code)
						ST_START, ST_REP_START, ST_MTX_ADR_ACK, ST_MTX_DATA_ACK: begin
							if (ptr < flen && ptr < BUFFER_DEPTH) begin
								res.tx_byte = frame_mem[AW'(ptr)];
								ptr++;
								res.bus_action = ACT_TX;
							end else begin
								success = 1'b1;
								busy = 1'b0;
								res.bus_action = ACT_STOP;
							end
						end
						ST_MRX_ADR_ACK, ST_MRX_DATA_ACK: begin
							if (code == ST_MRX_DATA_ACK && ptr < flen && ptr < BUFFER_DEPTH) begin
								frame_mem[AW'(ptr)] = data;
								ptr++;
							end
							res.bus_action = (ptr + 1 < flen) ? ACT_RX_ACK : ACT_RX_NACK;
						end
						ST_MRX_DATA_NACK: begin
							if (ptr < flen && ptr < BUFFER_DEPTH)
								frame_mem[AW'(ptr)] = data;
							success = 1'b1;
							busy = 1'b0;
							res.bus_action = ACT_STOP;
						end
						ST_ARB_LOST: begin
							res.bus_action = ACT_START;
						end
						default: begin
							ecode = status;
							err = 1'b1;
							busy = 1'b0;
							res.bus_action = ACT_DISABLE;
						end
					endcase
				end
			end
			MODE_READ: begin
				if (!busy && success && slot < BUFFER_DEPTH) begin
					res.read_byte = frame_mem[AW'(slot)];
					res.read_valid = 1'b1;
				end
			end
			MODE_RETRY: begin
				if (!busy && err && ((ecode & STATUS_MASK) == ST_MTX_ADR_NACK ||
						(ecode & STATUS_MASK) == ST_MRX_ADR_NACK)) begin
					success = 1'b0;
					err = 1'b0;
					ecode = 8'h00;
					busy = 1'b1;
					res.bus_action = ACT_START;
				end
			end
			default: begin
			end
		endcase
		res.busy_res     = busy;
		res.transfer_ok  = success;
		res.error_valid  = err;
		res.error_status = ecode;
	endtask

	task automatic compare_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
		if (exp_v !== act_v) begin
			failures++;
			$display("%0t ns: %s expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		seq_result_t want;
		seq_result_t got;
		if (!arst_n) begin
			expected_q.delete();
			ptr = 0;
			flen = 0;
			busy = 1'b0;
			success = 1'b0;
			err = 1'b0;
			ecode = 8'h00;
			outstanding <= 0;
			mismatch_count <= failures;
		end else begin
			if (m_tvalid && m_tready) begin
				got = seq_result_t'(m_tdata);
				if (expected_q.size() == 0) begin
					failures++;
					$display("%0t ns: result item with nothing expected, actual 0x%0h", $time, m_tdata);
				end else begin
					want = expected_q.pop_front();
					compare_field("bus_action", 8'(want.bus_action), 8'(got.bus_action));
					compare_field("tx_byte", want.tx_byte, got.tx_byte);
					compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
					compare_field("transfer_ok", 8'(want.transfer_ok), 8'(got.transfer_ok));
					compare_field("error_valid", 8'(want.error_valid), 8'(got.error_valid));
					compare_field("error_status", want.error_status, got.error_status);
					compare_field("read_byte", want.read_byte, got.read_byte);
					compare_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
				end
			end
			if (s_tvalid && s_tready) begin
				predict_result(s_tdata, want);
				expected_q.push_back(want);
			end
			outstanding <= expected_q.size();
			mismatch_count <= failures;
		end
	end

endmodule

>>> tb/sv/tb_i2c_master_transfer_sequencer.sv
`timescale 1ns / 100ps
// Top of the transfer sequencer testbench: clock, reset, stimulus and verdict.
module tb_i2c_master_transfer_sequencer import i2cm_pkg::*;;

	localparam int IDLE_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// mode[2:0], device_address[9:3], read_not_write[10], byte_count[14:11],
	// byte_index[18:15], data_byte[26:19], bus_status[34:27], zero[39:35]
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// bus_action[2:0], tx_byte[10:3], busy_res[11], transfer_ok[12],
	// error_valid[13], error_status[21:14], read_byte[29:22], read_valid[30], zero[31]
	logic [31:0] m_tdata;

	int mismatch_count;
	int outstanding;
	int idle_cycles = 0;
	int burst_left = 0;
	int sent_items = 0;

	always #4 clk = ~clk;

	i2c_master_transfer_sequencer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	i2c_master_transfer_sequencer_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	task automatic send_cmd(input logic [2:0] mode, input logic [6:0] addr, input logic rnw,
			input logic [3:0] count, input logic [3:0] idx, input logic [7:0] data,
			input logic [7:0] status);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, status, data, idx, count, rnw, addr, mode};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		sent_items++;
	endtask

	task automatic send_event(input logic [7:0] code);
		send_cmd(MODE_EVENT, 7'($urandom), 1'($urandom), 4'($urandom), 4'($urandom),
			8'($urandom), code | 8'($urandom_range(0, 3)));
	endtask

	initial begin
		int kind;
		int cnt;
		int n;
		logic rnw;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill every payload slot once so that no later transmit or read sees an unwritten slot.
		for (int i = 0; i < 15; i++)
			send_cmd(MODE_LOAD, 7'($urandom), 1'($urandom), 4'($urandom), 4'(i),
				(i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom), 8'($urandom));

		send_cmd(MODE_LOAD, 7'h00, 1'b0, 4'h0, 4'hF, 8'hFF, 8'h00);
		send_cmd(MODE_START, 7'h7F, 1'b0, 4'h0, 4'h0, 8'h00, 8'h00);
		send_cmd(MODE_LOAD, 7'h00, 1'b0, 4'h0, 4'h3, 8'hA5, 8'h00);
		send_cmd(MODE_START, 7'h12, 1'b1, 4'h5, 4'h0, 8'h00, 8'h00);
		send_cmd(MODE_READ, 7'h00, 1'b0, 4'h0, 4'h2, 8'h00, 8'h00);
		send_cmd(MODE_RETRY, 7'h00, 1'b0, 4'h0, 4'h0, 8'h00, 8'h00);
		send_cmd(MODE_EVENT, 7'h7F, 1'b1, 4'hF, 4'hF, 8'hFF, ST_START | 8'h03);
		send_cmd(MODE_EVENT, 7'h00, 1'b0, 4'h0, 4'h0, 8'h00, ST_MTX_ADR_ACK);
		send_cmd(MODE_READ, 7'h00, 1'b0, 4'h0, 4'hE, 8'h00, 8'h00);
		send_cmd(MODE_READ, 7'h00, 1'b0, 4'h0, 4'hF, 8'h00, 8'h00);
		send_cmd(MODE_EVENT, 7'h00, 1'b0, 4'h0, 4'h0, 8'h00, ST_START);
		send_cmd(3'd7, 7'h7F, 1'b1, 4'hF, 4'hF, 8'hFF, 8'hFF);
		send_cmd(MODE_START, 7'h00, 1'b1, 4'hF, 4'h0, 8'h00, 8'h00);
		send_cmd(MODE_EVENT, 7'h00, 1'b0, 4'h0, 4'h0, 8'h00, ST_START);
		send_cmd(MODE_EVENT, 7'h00, 1'b0, 4'h0, 4'h0, 8'h00, ST_MRX_ADR_NACK | 8'h01);
		send_cmd(MODE_READ, 7'h00, 1'b0, 4'h0, 4'h1, 8'h00, 8'h00);
		send_cmd(MODE_RETRY, 7'h00, 1'b0, 4'h0, 4'h0, 8'h00, 8'h00);
		send_cmd(MODE_EVENT, 7'h00, 1'b0, 4'h0, 4'h0, 8'h00, ST_ARB_LOST);
		send_cmd(MODE_EVENT, 7'h00, 1'b0, 4'h0, 4'h0, 8'h00, ST_REP_START | 8'h02);
		send_cmd(MODE_EVENT, 7'h00, 1'b0, 4'h0, 4'h0, 8'h00, ST_MRX_ADR_ACK);
		send_cmd(MODE_EVENT, 7'h00, 1'b0, 4'h0, 4'h0, 8'h00, ST_MRX_DATA_ACK);
		send_cmd(MODE_EVENT, 7'h00, 1'b0, 4'h0, 4'h0, 8'hFF, 8'hF8);
		send_cmd(MODE_RETRY, 7'h00, 1'b0, 4'h0, 4'h0, 8'h00, 8'h00);
		send_cmd(MODE_START, 7'h55, 1'b0, 4'h2, 4'h0, 8'h00, 8'h00);
		send_cmd(MODE_EVENT, 7'h00, 1'b0, 4'h0, 4'h0, 8'h00, ST_MTX_ADR_NACK);

		while (sent_items < 400) begin
			kind = $urandom_range(0, 9);
			cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 15) : $urandom_range(0, 4);
			if (kind <= 6) begin
				rnw = (kind >= 4);
				if (!rnw) begin
					n = $urandom_range(0, 3);
					repeat (n) send_cmd(MODE_LOAD, 7'($urandom), 1'($urandom), 4'($urandom),
						4'($urandom_range(0, 15)), 8'($urandom), 8'($urandom));
				end
				send_cmd(MODE_START, 7'($urandom), rnw, 4'(cnt), 4'($urandom), 8'($urandom),
					8'($urandom));
				send_event($urandom_range(0, 1) ? ST_START : ST_REP_START);
				if ($urandom_range(0, 7) == 0) begin
					send_event(rnw ? ST_MRX_ADR_NACK : ST_MTX_ADR_NACK);
					send_cmd(MODE_RETRY, 7'($urandom), 1'($urandom), 4'($urandom), 4'($urandom),
						8'($urandom), 8'($urandom));
					send_event(ST_REP_START);
				end
				if (!rnw) begin
					send_event(ST_MTX_ADR_ACK);
					repeat (cnt) begin
						if ($urandom_range(0, 15) == 0)
							send_event(ST_ARB_LOST);
						send_event(ST_MTX_DATA_ACK);
					end
					if ($urandom_range(0, 3) == 0)
						send_event(ST_MTX_DATA_ACK);
				end else begin
					send_event(ST_MRX_ADR_ACK);
					for (int i = 1; i < cnt; i++)
						send_event(ST_MRX_DATA_ACK);
					if ($urandom_range(0, 5) == 0)
						send_event(ST_MRX_DATA_ACK);
					send_event(ST_MRX_DATA_NACK);
					n = $urandom_range(1, 3);
					repeat (n) send_cmd(MODE_READ, 7'($urandom), 1'($urandom), 4'($urandom),
						4'($urandom_range(0, 15)), 8'($urandom), 8'($urandom));
				end
			end else if (kind <= 8) begin
				n = $urandom_range(1, 4);
				repeat (n) send_cmd(3'($urandom_range(0, 7)), 7'($urandom), 1'($urandom),
					4'($urandom), 4'($urandom), 8'($urandom), 8'($urandom));
			end else begin
				send_cmd(MODE_START, 7'($urandom), 1'($urandom), 4'(cnt), 4'($urandom),
					8'($urandom), 8'($urandom));
				n = $urandom_range(1, 4);
				repeat (n) send_cmd(MODE_EVENT, 7'($urandom), 1'($urandom), 4'($urandom),
					4'($urandom), 8'($urandom), 8'($urandom));
				send_cmd(MODE_RETRY, 7'($urandom), 1'($urandom), 4'($urandom), 4'($urandom),
					8'($urandom), 8'($urandom));
			end
		end
		s_tvalid <= 1'b0;
		@(posedge clk);

		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		int kind;
		int phase_len;
		@(posedge arst_n);
		repeat (20) begin
			@(posedge clk);
			m_tready <= ($urandom_range(0, 3) != 0);
		end
		// Long hold-off while items keep coming, so that the input side backs up.
		@(posedge clk);
		m_tready <= 1'b0;
		repeat (120) @(posedge clk);
		forever begin
			kind = $urandom_range(0, 9);
			phase_len = $urandom_range(10, 50);
			repeat (phase_len) begin
				@(posedge clk);
				if (kind < 4)
					m_tready <= 1'b1;
				else if (kind == 4)
					m_tready <= 1'b0;
				else
					m_tready <= ($urandom_range(0, 2) != 0);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

endmodule
